@@ hdl/linked_buffer_queue_manager_top_defines.svh @@
// ----------------------------------------------------------------------------
// Linked buffer queue manager assertion macros
// Shared property wrappers for the queue manager checks.
// ----------------------------------------------------------------------------
`ifndef LINKED_BUFFER_QUEUE_MANAGER_TOP_DEFINES_SVH
`define LINKED_BUFFER_QUEUE_MANAGER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define LBQM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define LBQM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lbqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Linked buffer queue manager package
// Widths, operation codes, controller states and transaction types.
// ----------------------------------------------------------------------------
package lbqm_pkg;

	localparam int IdW        = 8;
	localparam int OpW        = 3;
	localparam int QSelW      = 3;
	localparam int LinkDepth  = 256;
	localparam int NumQueues  = 8;
	localparam logic [IdW-1:0] MaxBuffers = 8'd255;
	localparam logic [IdW-1:0] CountMax   = 8'd255;

	typedef enum logic [OpW-1:0] {
		OP_INIT    = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_APPEND  = 3'd3,
		OP_INSERT  = 3'd4,
		OP_PULL    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_APP2,
		ST_INIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [QSelW-1:0] queue_sel;
		logic [IdW-1:0]   buf_id;
	} in_item_t;

	typedef struct packed {
		logic [IdW-1:0] got_id;
		logic [IdW-1:0] free_count;
		logic           queue_empty;
		logic           pool_busy;
	} out_item_t;

endpackage

@@ hdl/lbqm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lbqm_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/linked_buffer_queue_manager_top.sv @@
// ----------------------------------------------------------------------------
// Linked buffer queue manager
// Free list and user queues of numbered buffers, linked through one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel : in_valid/in_ready, in_data holds op, queue_sel, buf_id.
//   out channel : out_valid/out_ready, out_data holds got_id, free_count,
//                 queue_empty and pool_busy; one result per input transaction.
//   cfg channel : cfg_valid/cfg_ready, cfg_data writes num_buffers; write it
//                 only while no transaction is in flight.
// States, from input acceptance to result in the output register:
//   alloc or pull of a non-empty list : EXEC, READ, DONE
//   append to a non-empty queue       : EXEC, APP2, DONE
//   init : EXEC, INIT per buffer, DONE; every other operation : EXEC, DONE
// The next input is taken once the result is loaded and the controller is idle.
// One transaction is worked at a time; the link RAM port and its registered
// read set the steps, init writes one link word per cycle.
// Reset clears heads, tails and the free count; the link RAM is not cleared,
// init builds it. A result waiting in the output register does not block
// the next input; a finished result waits in place while out_ready is low.
// ----------------------------------------------------------------------------
module linked_buffer_queue_manager_top
	import lbqm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  in_item_t       in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output out_item_t      out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [IdW-1:0] cfg_data
);

	`include "linked_buffer_queue_manager_top_defines.svh"

	state_t           state_q, state_d;
	logic [IdW-1:0]   num_buffers_q;
	logic [OpW-1:0]   op_q;
	logic [QSelW-1:0] sel_q;
	logic [IdW-1:0]   id_q;
	logic [IdW-1:0]   got_q, got_d;
	logic [IdW-1:0]   free_head_q, free_head_d;
	logic [IdW-1:0]   free_tail_q, free_tail_d;
	logic [IdW-1:0]   free_total_q, free_total_d;
	logic [IdW-1:0]   qhead_q [NumQueues];
	logic [IdW-1:0]   qtail_q [NumQueues];
	logic [IdW-1:0]   q_head_d, q_tail_d;
	logic             q_wr, q_clear;
	logic [IdW-1:0]   cnt_q, cnt_d;
	logic             out_valid_q, out_load;
	out_item_t        out_q;

	logic             ram_we;
	logic [IdW-1:0]   ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	logic [IdW-1:0]   n_eff;
	logic             qok, accept;
	logic [IdW-1:0]   cur_qh, cur_qt;

	assign n_eff     = (num_buffers_q > MaxBuffers) ? MaxBuffers : num_buffers_q;
	assign qok       = int'(sel_q) < NumQueues;
	assign cur_qh    = qhead_q[sel_q];
	assign cur_qt    = qtail_q[sel_q];
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lbqm_ram #(
		.Width(IdW),
		.Depth(LinkDepth)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		got_d        = got_q;
		free_head_d  = free_head_q;
		free_tail_d  = free_tail_q;
		free_total_d = free_total_q;
		q_head_d     = cur_qh;
		q_tail_d     = cur_qt;
		q_wr         = 1'b0;
		q_clear      = 1'b0;
		cnt_d        = cnt_q;
		out_load     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = id_q;
		ram_wdata    = '0;
		ram_raddr    = free_head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				got_d   = '0;
				state_d = ST_DONE;
				case (op_t'(op_q))
					OP_INIT: begin
						q_clear = 1'b1;
						if (n_eff == '0) begin
							free_head_d  = '0;
							free_tail_d  = '0;
							free_total_d = '0;
						end else begin
							cnt_d   = IdW'(1);
							state_d = ST_INIT;
						end
					end
					OP_ALLOC: begin
						if (free_head_q != '0) begin
							ram_raddr = free_head_q;
							state_d   = ST_READ;
						end
					end
					OP_RELEASE: begin
						if (id_q != '0) begin
							ram_we      = 1'b1;
							ram_waddr   = id_q;
							ram_wdata   = free_head_q;
							free_head_d = id_q;
							if (free_tail_q == '0) begin
								free_tail_d = id_q;
							end
							if (free_total_q != CountMax) begin
								free_total_d = free_total_q + IdW'(1);
							end
						end
					end
					OP_APPEND: begin
						if (id_q != '0 && qok) begin
							ram_we    = 1'b1;
							ram_waddr = id_q;
							ram_wdata = '0;
							if (cur_qt != '0) begin
								state_d = ST_APP2;
							end else begin
								q_wr     = 1'b1;
								q_tail_d = id_q;
								q_head_d = (cur_qh == '0) ? id_q : cur_qh;
							end
						end
					end
					OP_INSERT: begin
						if (id_q != '0 && qok) begin
							ram_we    = 1'b1;
							ram_waddr = id_q;
							ram_wdata = cur_qh;
							q_wr      = 1'b1;
							q_head_d  = id_q;
							q_tail_d  = (cur_qt == '0) ? id_q : cur_qt;
						end
					end
					OP_PULL: begin
						if (qok && cur_qh != '0) begin
							ram_raddr = cur_qh;
							state_d   = ST_READ;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_READ: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				state_d   = ST_DONE;
				if (op_t'(op_q) == OP_ALLOC) begin
					got_d       = free_head_q;
					ram_waddr   = free_head_q;
					free_head_d = ram_rdata;
					if (ram_rdata == '0) begin
						free_tail_d = '0;
					end
					if (free_total_q != '0) begin
						free_total_d = free_total_q - IdW'(1);
					end
				end else begin
					got_d     = cur_qh;
					ram_waddr = cur_qh;
					q_wr      = 1'b1;
					q_head_d  = ram_rdata;
					q_tail_d  = (ram_rdata == '0) ? '0 : cur_qt;
				end
			end
			ST_APP2: begin
				ram_we    = 1'b1;
				ram_waddr = cur_qt;
				ram_wdata = id_q;
				q_wr      = 1'b1;
				q_tail_d  = id_q;
				q_head_d  = (cur_qh == '0) ? id_q : cur_qh;
				state_d   = ST_DONE;
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = (cnt_q < n_eff) ? cnt_q + IdW'(1) : '0;
				if (cnt_q == n_eff) begin
					free_head_d  = IdW'(1);
					free_tail_d  = n_eff;
					free_total_d = n_eff;
					state_d      = ST_DONE;
				end else begin
					cnt_d = cnt_q + IdW'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			num_buffers_q <= 8'd255;
			free_head_q   <= '0;
			free_tail_q   <= '0;
			free_total_q  <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
			for (int i = 0; i < NumQueues; i++) begin
				qhead_q[i] <= '0;
				qtail_q[i] <= '0;
			end
		end else begin
			state_q      <= state_d;
			free_head_q  <= free_head_d;
			free_tail_q  <= free_tail_d;
			free_total_q <= free_total_d;
			cnt_q        <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				num_buffers_q <= cfg_data;
			end
			if (q_clear) begin
				for (int i = 0; i < NumQueues; i++) begin
					qhead_q[i] <= '0;
					qtail_q[i] <= '0;
				end
			end else if (q_wr) begin
				qhead_q[sel_q] <= q_head_d;
				qtail_q[sel_q] <= q_tail_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_data.op;
			sel_q <= in_data.queue_sel;
			id_q  <= in_data.buf_id;
		end
		got_q <= got_d;
		if (out_load) begin
			out_q.got_id      <= got_q;
			out_q.free_count  <= free_total_q;
			out_q.queue_empty <= qok ? (cur_qh == '0) : 1'b1;
			out_q.pool_busy   <= free_total_q < n_eff;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LBQM_ASSERT_NEXT(a_one_in_flight, accept, !in_ready,
		"input accepted while a transaction is in flight")
	`LBQM_ASSERT_NEXT(a_result_loaded, (state_q == ST_DONE) && (!out_valid_q || out_ready),
		out_valid && (state_q == ST_IDLE), "finished result not presented")
	`LBQM_ASSERT_NEXT(a_init_count, (state_q == ST_INIT) && (cnt_q == n_eff),
		(free_total_q == $past(n_eff)) && (free_head_q == IdW'(1)),
		"free list not rebuilt by init")

endmodule
